/* rtl/core/idq_pkg.sv */
// shared constants, types and index helpers for the indexed deque
`default_nettype none

package idq_pkg;

	localparam int DEPTH  = 32;
	localparam int DATA_W = 32;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = 5;
	localparam int STAT_W = 3;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_RESIZE     = 3'd4,
		CMD_READ       = 3'd5,
		CMD_WRITE      = 3'd6,
		CMD_DUMP       = 3'd7
	} cmd_t;

	localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE = 3'd3;
	localparam logic [STAT_W-1:0] STAT_SIZE  = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic dump_step;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_dump;
		logic dump_last;
	} ctrl_stat_t;

	// slot holding position pos, with head < DEPTH and pos < DEPTH
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
			input logic [CNT_W-1:0] pos);
		logic [CNT_W:0] s;
		s = {{(CNT_W + 1 - PTR_W){1'b0}}, head} + {1'b0, pos};
		if (s >= (CNT_W + 1)'(DEPTH))
			s = s - (CNT_W + 1)'(DEPTH);
		return s[PTR_W-1:0];
	endfunction

	// position from the front of the element stored in a slot
	function automatic logic [PTR_W-1:0] pos_of(input logic [PTR_W-1:0] head,
			input logic [PTR_W-1:0] slot);
		logic [CNT_W:0] p;
		p = {{(CNT_W + 1 - PTR_W){1'b0}}, slot} + (CNT_W + 1)'(DEPTH)
			- {{(CNT_W + 1 - PTR_W){1'b0}}, head};
		if (p >= (CNT_W + 1)'(DEPTH))
			p = p - (CNT_W + 1)'(DEPTH);
		return p[PTR_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/idq_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module idq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/idq_ctrl.sv */
// command sequencer for the indexed deque
`default_nettype none

module idq_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire idq_pkg::ctrl_stat_t stat,
	output idq_pkg::ctrl_cmd_t       ctrl,
	output logic                     busy
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DUMP = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = (stat.is_dump && !stat.dump_last) ? S_DUMP : S_IDLE;
			end
			S_DUMP: begin
				if (stat.dump_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy           = (state_q != S_IDLE);
	assign ctrl.accept    = (state_q == S_IDLE) && start;
	assign ctrl.exec      = (state_q == S_EXEC);
	assign ctrl.dump_step = (state_q == S_DUMP);

endmodule

`default_nettype wire

/* rtl/core/idq_dp.sv */
// ring buffer datapath: pointers, written bits, storage and result registers
`default_nettype none

module idq_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire idq_pkg::ctrl_cmd_t                ctrl,
	input  wire logic [2:0]                        cmd,
	input  wire logic signed [idq_pkg::DATA_W-1:0] value,
	input  wire logic [idq_pkg::IDX_W-1:0]         index,
	input  wire logic [idq_pkg::CNT_W-1:0]         new_size,
	output idq_pkg::ctrl_stat_t                    stat,
	output logic                                   valid,
	output logic signed [idq_pkg::DATA_W-1:0]      data,
	output logic [idq_pkg::CNT_W-1:0]              size,
	output logic [idq_pkg::STAT_W-1:0]             status,
	output logic                                   last
);

	localparam int PW = idq_pkg::PTR_W;
	localparam int CW = idq_pkg::CNT_W;
	localparam int DW = idq_pkg::DATA_W;
	localparam int D  = idq_pkg::DEPTH;

	// latched command
	idq_pkg::cmd_t           cmd_q;
	logic [DW-1:0]           value_q;
	logic [idq_pkg::IDX_W-1:0] index_q;
	logic [CW-1:0]           nsz_q;

	logic [PW-1:0]  head_q, head_d;
	logic [CW-1:0]  count_q, count_d;
	logic [D-1:0]   written_q, written_d;
	logic [CW-1:0]  dump_pos_q;
	logic [PW-1:0]  rd_slot_q;

	logic           valid_q;
	logic [DW-1:0]  data_q, data_d;
	logic [CW-1:0]  size_q;
	logic [idq_pkg::STAT_W-1:0] status_q, status_d;
	logic           last_q, last_d;

	logic           we;
	logic [PW-1:0]  waddr;
	logic [PW-1:0]  raddr;
	logic [CW-1:0]  rpos;
	logic [DW-1:0]  rdata;
	logic [DW-1:0]  rd_word;

	idq_ram #(.WIDTH(DW), .DEPTH(D)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// a slot never written since it was exposed reads as zero
	assign rd_word = written_q[rd_slot_q] ? rdata : '0;

	assign stat.is_dump   = (cmd_q == idq_pkg::CMD_DUMP);
	assign stat.dump_last = ctrl.exec ? (count_q <= CW'(1)) : (dump_pos_q + CW'(1) == count_q);

	// read address: element at the requested index on accept, then the dump walk
	always_comb begin
		if (ctrl.accept)
			rpos = (idq_pkg::cmd_t'(cmd) == idq_pkg::CMD_DUMP) ? '0 : CW'(index);
		else if (ctrl.exec)
			rpos = CW'(1);
		else
			rpos = dump_pos_q + CW'(1);
		if (rpos >= CW'(D))
			rpos = '0;
		raddr = idq_pkg::slot_of(head_q, rpos);
	end

	always_comb begin
		logic [PW-1:0] p;
		p         = '0;
		head_d    = head_q;
		count_d   = count_q;
		written_d = written_q;
		we        = 1'b0;
		waddr     = idq_pkg::slot_of(head_q, CW'(index_q));
		status_d  = idq_pkg::STAT_OK;
		data_d    = '0;
		last_d    = 1'b1;
		if (ctrl.exec) begin
			case (cmd_q)
				idq_pkg::CMD_PUSH_BACK, idq_pkg::CMD_PUSH_FRONT: begin
					if (count_q >= CW'(D)) begin
						status_d = idq_pkg::STAT_FULL;
					end else begin
						if (cmd_q == idq_pkg::CMD_PUSH_BACK) begin
							waddr = idq_pkg::slot_of(head_q, count_q);
						end else begin
							head_d = (head_q == '0) ? PW'(D - 1) : head_q - PW'(1);
							waddr  = head_d;
						end
						we               = 1'b1;
						written_d[waddr] = 1'b1;
						count_d          = count_q + CW'(1);
					end
				end
				idq_pkg::CMD_POP_FRONT, idq_pkg::CMD_POP_BACK: begin
					if (count_q == '0) begin
						status_d = idq_pkg::STAT_EMPTY;
					end else begin
						if (cmd_q == idq_pkg::CMD_POP_FRONT)
							head_d = idq_pkg::slot_of(head_q, CW'(1));
						count_d = count_q - CW'(1);
					end
				end
				idq_pkg::CMD_RESIZE: begin
					if (nsz_q > CW'(D)) begin
						status_d = idq_pkg::STAT_SIZE;
					end else begin
						// clear written bits of the slots that growth exposes
						for (int j = 0; j < D; j++) begin
							p = idq_pkg::pos_of(head_q, PW'(j));
							if (CW'(p) >= count_q && CW'(p) < nsz_q)
								written_d[j] = 1'b0;
						end
						count_d = nsz_q;
					end
				end
				idq_pkg::CMD_READ: begin
					if (CW'(index_q) >= count_q)
						status_d = idq_pkg::STAT_RANGE;
					else
						data_d = rd_word;
				end
				idq_pkg::CMD_WRITE: begin
					if (CW'(index_q) >= count_q) begin
						status_d = idq_pkg::STAT_RANGE;
					end else begin
						we               = 1'b1;
						written_d[waddr] = 1'b1;
					end
				end
				idq_pkg::CMD_DUMP: begin
					if (count_q == '0) begin
						status_d = idq_pkg::STAT_EMPTY;
					end else begin
						data_d = rd_word;
						last_d = stat.dump_last;
					end
				end
				default: status_d = idq_pkg::STAT_OK;
			endcase
		end else if (ctrl.dump_step) begin
			data_d = rd_word;
			last_d = stat.dump_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			written_q  <= '0;
			dump_pos_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			head_q    <= head_d;
			count_q   <= count_d;
			written_q <= written_d;
			valid_q   <= ctrl.exec || ctrl.dump_step;
			if (ctrl.exec)
				dump_pos_q <= CW'(1);
			else if (ctrl.dump_step)
				dump_pos_q <= dump_pos_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		rd_slot_q <= raddr;
		if (ctrl.accept) begin
			cmd_q   <= idq_pkg::cmd_t'(cmd);
			value_q <= value;
			index_q <= index;
			nsz_q   <= new_size;
		end
		data_q   <= data_d;
		size_q   <= count_d;
		status_q <= status_d;
		last_q   <= last_d;
	end

	assign valid  = valid_q;
	assign data   = data_q;
	assign size   = size_q;
	assign status = status_q;
	assign last   = last_q;

endmodule

`default_nettype wire

/* rtl/core/indexed_deque_with_resize.sv */
// top level of the indexed deque with resize
//
// A bounded double-ended vector of 32 signed 32-bit elements in a ring buffer.
// A command word is taken at a rising edge with start high and busy low; busy
// rises the next cycle. Every command but dump gives one result word on data,
// size, status and last, shown for one cycle with valid high: the command
// runs in the exec state, and the result is registered and shown once the
// block is back in idle, with busy already low, so a new command may be
// started then. Dump gives one word per element, one per cycle, the final one
// with last set; the walk is paced by the storage ram's single registered
// read port. Dump of an empty vector gives one word, status empty.
// Read and dump data are zero for slots exposed by a resize and not written.
// Reset clears the head, the element count and the written bits at once; no
// clearing pass is needed. Results cannot be held off: a word lasts one cycle.
`default_nettype none

module indexed_deque_with_resize (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [2:0]                        cmd,
	input  wire logic signed [idq_pkg::DATA_W-1:0] value,
	input  wire logic [idq_pkg::IDX_W-1:0]         index,
	input  wire logic [idq_pkg::CNT_W-1:0]         new_size,
	output logic                                   valid,
	output logic signed [idq_pkg::DATA_W-1:0]      data,
	output logic [idq_pkg::CNT_W-1:0]              size,
	output logic [idq_pkg::STAT_W-1:0]             status,
	output logic                                   last
);

	idq_pkg::ctrl_cmd_t  ctrl;
	idq_pkg::ctrl_stat_t stat;

	idq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	idq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cmd      (cmd),
		.value    (value),
		.index    (index),
		.new_size (new_size),
		.stat     (stat),
		.valid    (valid),
		.data     (data),
		.size     (size),
		.status   (status),
		.last     (last)
	);

	// an accepted word always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// the final word of a command comes when the block is free again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !busy)
		else $error("busy still high on final result word");

	// more dump words pending keeps the block busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("intermediate dump word while idle");

	// a dump word that is not final is followed at once by another
	a_dump_cont: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid)
		else $error("dump walk stopped before last word");

	// size never exceeds the buffer depth
	a_size_max: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> size <= idq_pkg::CNT_W'(idq_pkg::DEPTH))
		else $error("element count beyond depth");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// testbench for the indexed deque: directed and random commands checked against a local deque model
`timescale 1ns / 1ps

module tb_top;
	import idq_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_WORDS = 92;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [CNT_W-1:0]         size;
		logic [STAT_W-1:0]        status;
		logic                     last;
	} deque_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [2:0]               cmd = CMD_PUSH_BACK;
	logic signed [DATA_W-1:0] value = '0;
	logic [IDX_W-1:0]         index = '0;
	logic [CNT_W-1:0]         new_size = '0;
	wire logic                busy;
	wire logic                valid;
	wire logic signed [DATA_W-1:0] data;
	wire logic [CNT_W-1:0]    size;
	wire logic [STAT_W-1:0]   status;
	wire logic                last;

	// local copy of the deque
	logic signed [DATA_W-1:0] dq_data [DEPTH];
	logic                     dq_written [DEPTH];
	logic [PTR_W-1:0]         dq_head;
	logic [CNT_W-1:0]         dq_count;

	deque_word_t pending_words [$];
	int errors = 0;
	int quiet_cycles = 0;

	indexed_deque_with_resize DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.value    (value),
		.index    (index),
		.new_size (new_size),
		.valid    (valid),
		.data     (data),
		.size     (size),
		.status   (status),
		.last     (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// depth is a power of two, so the wrap is a plain truncation
	function automatic logic [PTR_W-1:0] ring_slot(input logic [CNT_W-1:0] pos);
		logic [CNT_W:0] sum;
		sum = dq_head + pos;
		return sum[PTR_W-1:0];
	endfunction

	task automatic predict_deque(input cmd_t op, input logic signed [DATA_W-1:0] val,
			input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] nsz);
		logic [STAT_W-1:0] st;
		logic signed [DATA_W-1:0] rd;
		logic [PTR_W-1:0] s;
		deque_word_t w;
		int k;
		st = STAT_OK;
		rd = '0;
		case (op)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (dq_count >= CNT_W'(DEPTH)) begin
					st = STAT_FULL;
				end else begin
					if (op == CMD_PUSH_BACK) begin
						s = ring_slot(dq_count);
					end else begin
						dq_head = dq_head - 1'b1;
						s = dq_head;
					end
					dq_data[s] = val;
					dq_written[s] = 1'b1;
					dq_count = dq_count + 1'b1;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (dq_count == 0) begin
					st = STAT_EMPTY;
				end else begin
					if (op == CMD_POP_FRONT)
						dq_head = dq_head + 1'b1;
					dq_count = dq_count - 1'b1;
				end
			end
			CMD_RESIZE: begin
				if (nsz > CNT_W'(DEPTH)) begin
					st = STAT_SIZE;
				end else begin
					for (k = dq_count; k < nsz; k++)
						dq_written[ring_slot(CNT_W'(k))] = 1'b0;
					dq_count = nsz;
				end
			end
			CMD_READ: begin
				if (idx >= dq_count) begin
					st = STAT_RANGE;
				end else begin
					s = ring_slot(CNT_W'(idx));
					rd = dq_written[s] ? dq_data[s] : '0;
				end
			end
			CMD_WRITE: begin
				if (idx >= dq_count) begin
					st = STAT_RANGE;
				end else begin
					s = ring_slot(CNT_W'(idx));
					dq_data[s] = val;
					dq_written[s] = 1'b1;
				end
			end
			default: begin
				// dump: one word per element, or a single empty word
				if (dq_count == 0) begin
					st = STAT_EMPTY;
				end else begin
					for (k = 0; k < dq_count; k++) begin
						s = ring_slot(CNT_W'(k));
						w.data = dq_written[s] ? dq_data[s] : '0;
						w.size = dq_count;
						w.status = STAT_OK;
						w.last = (k == dq_count - 1);
						pending_words.insert(pending_words.size(), w);
					end
					return;
				end
			end
		endcase
		w.data = rd;
		w.size = dq_count;
		w.status = st;
		w.last = 1'b1;
		pending_words.insert(pending_words.size(), w);
	endtask

	// entered right after a rising edge; returns at the edge that took the word
	task automatic issue_command(input cmd_t op, input logic signed [DATA_W-1:0] val,
			input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] nsz);
		start <= 1'b1;
		cmd <= op;
		value <= val;
		index <= idx;
		new_size <= nsz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_deque(op, val, idx, nsz);
	endtask

	task automatic idle_for(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// hold the sender until every expected word is back
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		deque_word_t w;
		if (arst_n && valid) begin
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t unexpected word: expected none actual %h %0d %0d %b",
					$time, data, size, status, last);
			end else begin
				w = pending_words[0];
				pending_words.delete(0);
				check_field("data", w.data, data);
				check_field("size", DATA_W'(w.size), DATA_W'(size));
				check_field("status", DATA_W'(w.status), DATA_W'(status));
				check_field("last", DATA_W'(w.last), DATA_W'(last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t watchdog: no progress, %0d words pending", $time, pending_words.size());
		$display("TB_ERROR");
		$finish;
	end

	task automatic test_empty_errors();
		issue_command(CMD_POP_FRONT, '0, '0, '0);
		issue_command(CMD_POP_BACK, '0, '0, '0);
		issue_command(CMD_READ, '0, '0, '0);
		wait_drained();
	endtask

	task automatic test_push_read();
		issue_command(CMD_PUSH_BACK, 32'sh7fff_ffff, '0, '0);
		issue_command(CMD_PUSH_FRONT, 32'sh8000_0000, '0, '0);
		issue_command(CMD_PUSH_BACK, '0, '0, '0);
		issue_command(CMD_PUSH_BACK, -32'sd1, '0, '0);
		issue_command(CMD_READ, '0, 5'd0, '0);
		issue_command(CMD_READ, '0, 5'd3, '0);
		issue_command(CMD_READ, '0, 5'd4, '0);
		issue_command(CMD_WRITE, 32'sh1234_5678, 5'd31, '0);
		issue_command(CMD_WRITE, 32'sh5a5a_a5a5, 5'd1, '0);
		issue_command(CMD_DUMP, '0, '0, '0);
		wait_drained();
	endtask

	task automatic test_resize();
		issue_command(CMD_RESIZE, '0, '0, 6'd33);
		issue_command(CMD_RESIZE, '0, '0, 6'd2);
		// growing back exposes slots that must read as zero
		issue_command(CMD_RESIZE, '0, '0, 6'd4);
		issue_command(CMD_READ, '0, 5'd3, '0);
		issue_command(CMD_DUMP, '0, '0, '0);
		wait_drained();
	endtask

	task automatic test_drain_to_empty();
		issue_command(CMD_POP_FRONT, '0, '0, '0);
		issue_command(CMD_POP_BACK, '0, '0, '0);
		issue_command(CMD_RESIZE, '0, '0, 6'd0);
		issue_command(CMD_POP_FRONT, '0, '0, '0);
		issue_command(CMD_DUMP, '0, '0, '0);
		wait_drained();
	endtask

	task automatic test_full();
		issue_command(CMD_RESIZE, '0, '0, 6'd32);
		issue_command(CMD_PUSH_BACK, 32'sh0bad_cafe, '0, '0);
		issue_command(CMD_PUSH_FRONT, 32'sh0bad_cafe, '0, '0);
		issue_command(CMD_WRITE, 32'sh8000_0000, 5'd31, '0);
		issue_command(CMD_READ, '0, 5'd31, '0);
		wait_drained();
	endtask

	task automatic issue_random();
		cmd_t op;
		logic signed [DATA_W-1:0] v;
		logic [IDX_W-1:0] ix;
		logic [CNT_W-1:0] ns;
		int r;
		r = $urandom_range(0, 99);
		if (r < 18)      op = CMD_PUSH_BACK;
		else if (r < 32) op = CMD_PUSH_FRONT;
		else if (r < 42) op = CMD_POP_FRONT;
		else if (r < 52) op = CMD_POP_BACK;
		else if (r < 60) op = CMD_RESIZE;
		else if (r < 75) op = CMD_READ;
		else if (r < 90) op = CMD_WRITE;
		else             op = CMD_DUMP;
		case ($urandom_range(0, 7))
			0: v = 32'sh7fff_ffff;
			1: v = 32'sh8000_0000;
			2: v = '0;
			default: v = DATA_W'($urandom);
		endcase
		if (dq_count != 0 && $urandom_range(0, 4) != 0)
			ix = IDX_W'($urandom_range(0, dq_count - 1));
		else
			ix = IDX_W'($urandom_range(0, 31));
		r = $urandom_range(0, 9);
		if (r == 0)
			ns = CNT_W'($urandom_range(33, 63));
		else if (r < 6)
			ns = CNT_W'($urandom_range(0, 8));
		else
			ns = CNT_W'($urandom_range(0, 32));
		issue_command(op, v, ix, ns);
	endtask

	task automatic test_random();
		int sent;
		int burst;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && sent < RANDOM_WORDS) begin
				issue_random();
				burst--;
				sent++;
				if (sent == RANDOM_WORDS / 2)
					wait_drained();
			end
			if ($urandom_range(0, 3) != 0)
				idle_for($urandom_range(1, 6));
		end
		wait_drained();
	endtask

	initial begin
		int k;
		for (k = 0; k < DEPTH; k++) begin
			dq_data[k] = '0;
			dq_written[k] = 1'b0;
		end
		dq_head = '0;
		dq_count = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_errors();
		test_push_read();
		test_resize();
		test_drain_to_empty();
		test_full();
		test_random();

		repeat (40) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
